FILE: rtl/bif_pkg.sv
// Shared types and constants of the bilateral image filter.
// Used by every module under rtl; depends on nothing.
package bif_pkg;

  localparam int unsigned MAX_RADIUS  = 15;
  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned MAX_HEIGHT  = 2048;
  localparam int unsigned SP_ENTRIES  = 2 * MAX_RADIUS + 1;
  localparam int unsigned RG_ENTRIES  = 512;
  localparam int unsigned LINE_DEPTH  = SP_ENTRIES * MAX_WIDTH;
  localparam int unsigned LINE_AW     = $clog2(LINE_DEPTH);
  localparam int unsigned SP_AW       = $clog2(SP_ENTRIES);
  localparam int unsigned RG_AW       = $clog2(RG_ENTRIES);
  localparam int unsigned DIM_W       = 12;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned PIX_W       = 12;
  localparam int unsigned WGT_W       = 16;
  localparam int unsigned ACC_W       = 38;
  localparam int unsigned WSUM_W      = 26;
  localparam int unsigned RANGE_SHIFT = 4;

  localparam logic [1:0] CMD_PIXEL   = 2'd0;
  localparam logic [1:0] CMD_FLUSH   = 2'd1;
  localparam logic [1:0] CMD_LOAD_SP = 2'd2;
  localparam logic [1:0] CMD_LOAD_RG = 2'd3;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [PIX_W-1:0] pixel_value;
    logic [8:0]       table_index;
    logic [WGT_W-1:0] table_weight;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_value;
    logic             zero_weight;
    logic             frame_last;
  } res_t;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_FLUSH,
    KIND_LOAD_SP,
    KIND_LOAD_RG
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             sp_ok;
    logic [PIX_W-1:0] pixel;
    logic [RG_AW-1:0] index;
    logic [WGT_W-1:0] weight;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } front_t;

endpackage

FILE: rtl/bif_front.sv
// Front end: two-entry request queue and command decode.
// Depends on bif_pkg.
module bif_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  bif_pkg::in_item_t in_item_i,
  output bif_pkg::front_t   front_o,
  input  logic              take_i
);

  bif_pkg::in_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;
  bif_pkg::in_item_t head;

  assign full  = (cnt_q == 2'd2);
  assign do_wr = push && !full;
  assign do_rd = take_i && (cnt_q != 2'd0);
  assign head  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= !wr_q;
      if (do_rd) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Classify the oldest request.
  always_comb begin
    front_o.valid      = (cnt_q != 2'd0);
    front_o.job.pixel  = head.pixel_value;
    front_o.job.index  = head.table_index;
    front_o.job.weight = head.table_weight;
    front_o.job.sp_ok  = ({23'd0, head.table_index} < 32'(bif_pkg::SP_ENTRIES));
    unique case (head.command)
      bif_pkg::CMD_PIXEL:   front_o.job.kind = bif_pkg::KIND_PIXEL;
      bif_pkg::CMD_FLUSH:   front_o.job.kind = bif_pkg::KIND_FLUSH;
      bif_pkg::CMD_LOAD_SP: front_o.job.kind = bif_pkg::KIND_LOAD_SP;
      default:              front_o.job.kind = bif_pkg::KIND_LOAD_RG;
    endcase
  end

endmodule

FILE: rtl/bif_outq.sv
// Two-entry result queue between the filter core and the output port.
// Depends on bif_pkg.
module bif_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bif_pkg::res_t wdata_i,
  output logic          full_o,
  output logic          empty,
  input  logic          pop,
  output bif_pkg::res_t rdata_o
);

  bif_pkg::res_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty   = (cnt_q == 2'd0);
  assign do_rd   = pop && !empty;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wr_q <= !wr_q;
      if (do_rd) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, do_rd};
    end
  end

endmodule

FILE: rtl/bif_back.sv
// Filter core: tables, line memory, tap walk, accumulate and divide.
// Depends on bif_pkg; fed by bif_front, drains into bif_outq.
module bif_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bif_pkg::front_t     front_i,
  output logic                take_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i,
  input  logic                oq_full_i,
  output logic                oq_wr_o,
  output bif_pkg::res_t       oq_data_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_CWAIT = 8'b0000_0100,
    ST_TAPS  = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_PUSH  = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_e;

  localparam logic [bif_pkg::LINE_AW-1:0] LineDepth = bif_pkg::LINE_AW'(bif_pkg::LINE_DEPTH);

  function automatic logic [bif_pkg::LINE_AW-1:0] wrap_add(
    input logic [bif_pkg::LINE_AW-1:0] a,
    input logic [bif_pkg::LINE_AW-1:0] b
  );
    logic [bif_pkg::LINE_AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, LineDepth}) s = s - {1'b0, LineDepth};
    return s[bif_pkg::LINE_AW-1:0];
  endfunction

  // Memories
  logic [bif_pkg::PIX_W-1:0] line_mem [bif_pkg::LINE_DEPTH];
  logic [bif_pkg::WGT_W-1:0] rg_mem   [bif_pkg::RG_ENTRIES];
  logic [bif_pkg::WGT_W-1:0] spy_mem  [bif_pkg::SP_ENTRIES];
  logic [bif_pkg::WGT_W-1:0] spx_mem  [bif_pkg::SP_ENTRIES];

  state_e state_q, state_d;

  logic [3:0]  radius_q;
  logic [11:0] width_q, height_q;
  logic [3:0]  r_eff;
  logic [11:0] w_eff, h_eff;

  logic [bif_pkg::POS_W-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
  logic [bif_pkg::LINE_AW-1:0] in_slot_q, out_slot_q;
  logic done_q;

  logic [4:0] ky_q, kx_q;
  logic signed [12:0] y_q, x_q;
  logic [bif_pkg::LINE_AW-1:0] row_slot_q, tap_slot_q;
  logic [bif_pkg::PIX_W-1:0] c_q;

  logic [bif_pkg::LINE_AW-1:0] line_raddr;
  logic [bif_pkg::PIX_W-1:0]   line_rdata;
  logic [bif_pkg::WGT_W-1:0]   sy_rdata, sx_rdata, rg_rdata;
  logic [bif_pkg::RG_AW-1:0]   rg_raddr;

  logic la_q, ia_q, lb_q, ib_q, lc_q, ic_q;
  logic [bif_pkg::PIX_W-1:0] pb_q, pc_q;
  logic [bif_pkg::WGT_W-1:0] ss_q, wt_q;
  logic [bif_pkg::ACC_W-1:0]  sum_q;
  logic [bif_pkg::WSUM_W-1:0] wsum_q;
  logic [bif_pkg::ACC_W-1:0]  rem_q;
  logic [bif_pkg::PIX_W-1:0]  quot_q;
  logic [3:0] dcnt_q;

  logic [11:0] nr, nc, h_m1, w_m1, in_col_n, out_col_n;
  logic ready, in_frame, last_kx, last_ky, is_last;
  logic [15:0] off;
  logic [bif_pkg::LINE_AW-1:0] base_slot;
  logic [4:0] kspan;
  logic [12:0] di_raw;
  logic [31:0] ss_prod, wt_prod;
  logic [bif_pkg::ACC_W-1:0] trial;
  logic item_act, restart;

  assign r_eff = (radius_q == 4'd0) ? 4'd1 : radius_q;
  assign w_eff = (width_q == 12'd0) ? 12'd1 :
                 (width_q > 12'(bif_pkg::MAX_WIDTH)) ? 12'(bif_pkg::MAX_WIDTH) : width_q;
  assign h_eff = (height_q == 12'd0) ? 12'd1 :
                 (height_q > 12'(bif_pkg::MAX_HEIGHT)) ? 12'(bif_pkg::MAX_HEIGHT) : height_q;
  assign h_m1  = h_eff - 12'd1;
  assign w_m1  = w_eff - 12'd1;
  assign kspan = {r_eff, 1'b0};

  // Output is ready once input has passed the bottom-right corner of its window, or once the frame is all in.
  always_comb begin
    nr = {1'b0, out_row_q} + {8'd0, r_eff};
    if (nr > h_m1) nr = h_m1;
    nc = {1'b0, out_col_q} + {8'd0, r_eff};
    if (nc > w_m1) nc = w_m1;
    ready = done_q || ({1'b0, in_row_q} > nr) ||
            (({1'b0, in_row_q} == nr) && ({1'b0, in_col_q} > nc));
  end

  assign off       = ({12'd0, r_eff} * {4'd0, w_eff}) + {12'd0, r_eff};
  assign base_slot = wrap_add(out_slot_q, LineDepth - off);
  assign in_frame  = (y_q >= 13'sd0) && (y_q < $signed({1'b0, h_eff})) &&
                     (x_q >= 13'sd0) && (x_q < $signed({1'b0, w_eff}));
  assign last_kx   = (kx_q == kspan);
  assign last_ky   = (ky_q == kspan);
  assign is_last   = ({1'b0, out_row_q} == h_m1) && ({1'b0, out_col_q} == w_m1);
  assign in_col_n  = {1'b0, in_col_q} + 12'd1;
  assign out_col_n = {1'b0, out_col_q} + 12'd1;

  assign take_o   = (state_q == ST_IDLE) && front_i.valid && !oq_full_i;
  assign item_act = take_o && (front_i.job.kind == bif_pkg::KIND_PIXEL) && !done_q;
  assign restart  = cfg_we_i && (cfg_index_i == bif_pkg::CFG_RADIUS ||
                    cfg_index_i == bif_pkg::CFG_WIDTH || cfg_index_i == bif_pkg::CFG_HEIGHT);

  // Table and line writes
  always_ff @(posedge clk_i) begin
    if (take_o && front_i.job.kind == bif_pkg::KIND_LOAD_SP && front_i.job.sp_ok) begin
      spy_mem[front_i.job.index[bif_pkg::SP_AW-1:0]] <= front_i.job.weight;
      spx_mem[front_i.job.index[bif_pkg::SP_AW-1:0]] <= front_i.job.weight;
    end
    if (take_o && front_i.job.kind == bif_pkg::KIND_LOAD_RG) begin
      rg_mem[front_i.job.index] <= front_i.job.weight;
    end
    if (item_act) begin
      line_mem[in_slot_q] <= front_i.job.pixel;
    end
  end

  assign line_raddr = (state_q == ST_CHECK) ? out_slot_q : tap_slot_q;
  assign di_raw     = {1'b0, line_rdata} - {1'b0, c_q} + 13'd4096;
  assign rg_raddr   = di_raw[12:bif_pkg::RANGE_SHIFT];
  assign ss_prod    = sy_rdata * sx_rdata;
  assign wt_prod    = ss_q * rg_rdata;

  // Registered reads
  always_ff @(posedge clk_i) begin
    line_rdata <= line_mem[line_raddr];
    sy_rdata   <= spy_mem[ky_q];
    sx_rdata   <= spx_mem[kx_q];
    rg_rdata   <= rg_mem[rg_raddr];
  end

  // Tap datapath: weight product, range weight, accumulate
  always_ff @(posedge clk_i) begin
    pb_q <= line_rdata;
    ss_q <= ss_prod[31:16];
    pc_q <= pb_q;
    wt_q <= wt_prod[31:16];
    if (state_q == ST_CWAIT) begin
      c_q    <= line_rdata;
      sum_q  <= '0;
      wsum_q <= '0;
    end else if (lc_q && ic_q) begin
      sum_q  <= sum_q + bif_pkg::ACC_W'(wt_q * pc_q);
      wsum_q <= wsum_q + bif_pkg::WSUM_W'(wt_q);
    end
  end

  assign trial = bif_pkg::ACC_W'({12'd0, wsum_q} << dcnt_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      rem_q  <= sum_q;
      quot_q <= '0;
    end else if (state_q == ST_DIV) begin
      if (rem_q >= trial) begin
        rem_q          <= rem_q - trial;
        quot_q[dcnt_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take_o && (front_i.job.kind == bif_pkg::KIND_PIXEL ||
                       front_i.job.kind == bif_pkg::KIND_FLUSH)) state_d = ST_CHECK;
      end
      ST_CHECK: state_d = ready ? ST_CWAIT : ST_IDLE;
      ST_CWAIT: state_d = ST_TAPS;
      ST_TAPS:  if (last_kx && last_ky) state_d = ST_DRAIN;
      ST_DRAIN: if (!la_q && !lb_q && !lc_q) state_d = ST_DIV;
      ST_DIV:   if (dcnt_q == 4'd0) state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign oq_wr_o = (state_q == ST_PUSH);
  assign oq_data_o.zero_weight    = (wsum_q == '0);
  assign oq_data_o.filtered_value = (wsum_q == '0) ? '0 : quot_q;
  assign oq_data_o.frame_last     = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      radius_q   <= 4'd1;
      width_q    <= 12'd640;
      height_q   <= 12'd480;
      in_row_q   <= '0;
      in_col_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      in_slot_q  <= '0;
      out_slot_q <= '0;
      done_q     <= 1'b0;
      ky_q       <= '0;
      kx_q       <= '0;
      y_q        <= '0;
      x_q        <= '0;
      row_slot_q <= '0;
      tap_slot_q <= '0;
      la_q       <= 1'b0;
      ia_q       <= 1'b0;
      lb_q       <= 1'b0;
      ib_q       <= 1'b0;
      lc_q       <= 1'b0;
      ic_q       <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      state_q <= state_d;
      lb_q <= la_q;
      ib_q <= ia_q;
      lc_q <= lb_q;
      ic_q <= ib_q;
      la_q <= (state_q == ST_TAPS);
      ia_q <= (state_q == ST_TAPS) && in_frame;

      if (cfg_we_i) begin
        case (cfg_index_i)
          bif_pkg::CFG_RADIUS: radius_q <= cfg_data_i[3:0];
          bif_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          bif_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (restart) begin
        in_row_q   <= '0;
        in_col_q   <= '0;
        out_row_q  <= '0;
        out_col_q  <= '0;
        in_slot_q  <= '0;
        out_slot_q <= '0;
        done_q     <= 1'b0;
      end else if (item_act) begin
        in_slot_q <= wrap_add(in_slot_q, bif_pkg::LINE_AW'(1));
        if (in_col_n >= w_eff) begin
          in_col_q <= '0;
          if ({1'b0, in_row_q} + 12'd1 >= h_eff) begin
            in_row_q <= '0;
            done_q   <= 1'b1;
          end else begin
            in_row_q <= in_row_q + 1'b1;
          end
        end else begin
          in_col_q <= in_col_n[bif_pkg::POS_W-1:0];
        end
      end else if (state_q == ST_PUSH) begin
        if (is_last) begin
          in_row_q   <= '0;
          in_col_q   <= '0;
          out_row_q  <= '0;
          out_col_q  <= '0;
          in_slot_q  <= '0;
          out_slot_q <= '0;
          done_q     <= 1'b0;
        end else begin
          out_slot_q <= wrap_add(out_slot_q, bif_pkg::LINE_AW'(1));
          if (out_col_n >= w_eff) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 1'b1;
          end else begin
            out_col_q <= out_col_n[bif_pkg::POS_W-1:0];
          end
        end
      end

      // Walk the window, one tap per cycle
      if (state_q == ST_CWAIT) begin
        ky_q       <= '0;
        kx_q       <= '0;
        y_q        <= $signed({2'b0, out_row_q}) - $signed({9'd0, r_eff});
        x_q        <= $signed({2'b0, out_col_q}) - $signed({9'd0, r_eff});
        row_slot_q <= base_slot;
        tap_slot_q <= base_slot;
      end else if (state_q == ST_TAPS) begin
        if (last_kx) begin
          kx_q       <= '0;
          x_q        <= $signed({2'b0, out_col_q}) - $signed({9'd0, r_eff});
          ky_q       <= ky_q + 5'd1;
          y_q        <= y_q + 13'sd1;
          row_slot_q <= wrap_add(row_slot_q, bif_pkg::LINE_AW'(w_eff));
          tap_slot_q <= wrap_add(row_slot_q, bif_pkg::LINE_AW'(w_eff));
        end else begin
          kx_q       <= kx_q + 5'd1;
          x_q        <= x_q + 13'sd1;
          tap_slot_q <= wrap_add(tap_slot_q, bif_pkg::LINE_AW'(1));
        end
      end

      if (state_q == ST_DRAIN) begin
        dcnt_q <= 4'(bif_pkg::PIX_W - 1);
      end else if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q - 4'd1;
      end
    end
  end

endmodule

FILE: rtl/bilateral_image_filter.sv
// Top level of the bilateral image filter: request queue, filter core, result queue.
// Depends on bif_pkg, bif_front, bif_back and bif_outq.
//
//   channel   handshake                 payload
//   input     push / full               in_item_i (command, pixel, table index, weight)
//   result    empty / pop               res_o (filtered value, zero weight, frame last)
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A table load is handled in the idle state; a pixel that completes no window goes
// through the check state and back to idle. A pixel or flush that releases an output
// runs the tap walk, one neighbor per cycle from line memory, then a 12-step divide.
// Reset clears positions and queues; tables and line memory hold garbage until written.
// Both queues hold two entries; no request is taken while the result queue is full.
module bilateral_image_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  bif_pkg::in_item_t in_item_i,
  output logic              empty,
  input  logic              pop,
  output bif_pkg::res_t     res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i
);

  bif_pkg::front_t front;
  bif_pkg::res_t   oq_data;
  logic take, oq_full, oq_wr;

  assign cfg_ready_o = 1'b1;

  bif_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .front_o   (front),
    .take_i    (take)
  );

  bif_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .front_i     (front),
    .take_o      (take),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .oq_full_i   (oq_full),
    .oq_wr_o     (oq_wr),
    .oq_data_o   (oq_data)
  );

  bif_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (oq_wr),
    .wdata_i (oq_data),
    .full_o  (oq_full),
    .empty   (empty),
    .pop     (pop),
    .rdata_o (res_o)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for bilateral_image_filter: table setup, directed requests,
// then random phases over several window and frame settings with a scoreboard.
// Depends on bif_pkg and the RTL under rtl.
module tb;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned N_PHASES = 12;

  typedef struct {
    bif_pkg::in_item_t item;
    bit                typed;
    bif_pkg::res_t     want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  bif_pkg::in_item_t in_item;
  logic              empty;
  logic              pop;
  bif_pkg::res_t     res;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [11:0]       cfg_data;

  // predictor state
  logic [11:0] line_mem [bif_pkg::LINE_DEPTH];
  logic [15:0] sp_tab [bif_pkg::SP_ENTRIES];
  logic [15:0] rg_tab [bif_pkg::RG_ENTRIES];
  int unsigned in_row, in_col, out_row, out_col;
  bit          input_done;
  int unsigned reg_radius, reg_width, reg_height;

  bif_pkg::res_t pending_q [$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_items;
  int unsigned cycle_cnt;
  int unsigned send_idle, recv_idle;
  int unsigned hold_tag, seen_tag, hold_cnt;

  dir_row_t dir_rows [$];

  bilateral_image_filter i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic bif_pkg::in_item_t mk(logic [1:0] cmd, int unsigned pix,
                                           int unsigned idx, int unsigned wt);
    bif_pkg::in_item_t it;
    it.command      = cmd;
    it.pixel_value  = pix[11:0];
    it.table_index  = idx[8:0];
    it.table_weight = wt[15:0];
    return it;
  endfunction

  function automatic void restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    input_done = 1'b0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [11:0] val);
    if (idx == bif_pkg::CFG_RADIUS) reg_radius = val[3:0];
    else if (idx == bif_pkg::CFG_WIDTH) reg_width = val;
    else if (idx == bif_pkg::CFG_HEIGHT) reg_height = val;
    else return;
    restart_frame();
  endfunction

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the filter state by one request; return 1 when it releases an output.
  function automatic bit filter_step(bif_pkg::in_item_t it, output bif_pkg::res_t r);
    int unsigned rad, w, h, nr, nc, c, p, di;
    longint unsigned acc, wsum, wt;
    int y, x;
    rad = clampu(reg_radius, bif_pkg::MAX_RADIUS);
    w = clampu(reg_width, bif_pkg::MAX_WIDTH);
    h = clampu(reg_height, bif_pkg::MAX_HEIGHT);
    r = '0;
    if (it.command == bif_pkg::CMD_LOAD_SP) begin
      if (it.table_index < bif_pkg::SP_ENTRIES) sp_tab[it.table_index] = it.table_weight;
      return 1'b0;
    end
    if (it.command == bif_pkg::CMD_LOAD_RG) begin
      rg_tab[it.table_index] = it.table_weight;
      return 1'b0;
    end
    if (it.command == bif_pkg::CMD_PIXEL && !input_done) begin
      line_mem[(in_row * w + in_col) % bif_pkg::LINE_DEPTH] = it.pixel_value;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          input_done = 1'b1;
        end
      end
    end
    if (!input_done) begin
      nr = out_row + rad; if (nr > h - 1) nr = h - 1;
      nc = out_col + rad; if (nc > w - 1) nc = w - 1;
      if (!(in_row * w + in_col > nr * w + nc)) return 1'b0;
    end
    c = line_mem[(out_row * w + out_col) % bif_pkg::LINE_DEPTH];
    acc = 0; wsum = 0;
    for (int ky = 0; ky <= 2 * rad; ky++) begin
      y = int'(out_row) + ky - int'(rad);
      if (y < 0 || y >= int'(h)) continue;
      for (int kx = 0; kx <= 2 * rad; kx++) begin
        x = int'(out_col) + kx - int'(rad);
        if (x < 0 || x >= int'(w)) continue;
        p = line_mem[(y * w + x) % bif_pkg::LINE_DEPTH];
        di = ((4096 + p - c) >> bif_pkg::RANGE_SHIFT) & (bif_pkg::RG_ENTRIES - 1);
        wt = (longint'(sp_tab[ky]) * sp_tab[kx]) >> 16;
        wt = (wt * rg_tab[di]) >> 16;
        acc += wt * p;
        wsum += wt;
      end
    end
    r.filtered_value = (wsum != 0) ? 12'((acc / wsum) & 'hFFF) : 12'd0;
    r.zero_weight    = (wsum == 0);
    r.frame_last     = (out_row == h - 1 && out_col == w - 1);
    if (r.frame_last) restart_frame();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_request(bif_pkg::in_item_t it, bit typed, bif_pkg::res_t want);
    bif_pkg::res_t r;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    n_items++;
    if (filter_step(it, r)) pending_q.push_back(typed ? want : r);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // hold valid across back-to-back writes; the caller drops it
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[11:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val[11:0]);
  endtask

  task automatic set_frame(int unsigned rad, int unsigned w, int unsigned h);
    write_reg(bif_pkg::CFG_RADIUS, rad);
    write_reg(bif_pkg::CFG_WIDTH, w);
    write_reg(bif_pkg::CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic bif_pkg::in_item_t rand_request();
    bif_pkg::in_item_t it;
    int unsigned k;
    it.command      = bif_pkg::CMD_PIXEL;
    it.pixel_value  = 12'($urandom);
    it.table_index  = 9'($urandom);
    it.table_weight = 16'($urandom);
    k = $urandom_range(99);
    if (k < 75) it.command = bif_pkg::CMD_PIXEL;
    else if (k < 87) it.command = bif_pkg::CMD_FLUSH;
    else if (k < 95) it.command = bif_pkg::CMD_LOAD_RG;
    else begin
      it.command = bif_pkg::CMD_LOAD_SP;
      // mostly valid spatial entries, some ignored ones
      if ($urandom_range(3) != 0) it.table_index = 9'($urandom_range(bif_pkg::SP_ENTRIES - 1));
    end
    if (it.command != bif_pkg::CMD_PIXEL && $urandom_range(9) == 0)
      it.table_weight = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return it;
  endfunction

  // result side: random pop, long hold on request, compare against oldest expectation
  always @(posedge clk) begin
    bif_pkg::res_t exp_r;
    if (pop && !empty) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %p", res);
        n_errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (res.filtered_value !== exp_r.filtered_value) begin
          $error("filtered_value exp %0d got %0d", exp_r.filtered_value, res.filtered_value);
          n_errors++;
        end
        if (res.zero_weight !== exp_r.zero_weight) begin
          $error("zero_weight exp %0d got %0d", exp_r.zero_weight, res.zero_weight);
          n_errors++;
        end
        if (res.frame_last !== exp_r.frame_last) begin
          $error("frame_last exp %0d got %0d", exp_r.frame_last, res.frame_last);
          n_errors++;
        end
      end
    end
    if (hold_tag != seen_tag) begin
      seen_tag = hold_tag;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int unsigned ph_r [N_PHASES] = '{1, 2, 0, 3, 15, 4, 1, 2, 1, 1, 7, 1};
    int unsigned ph_w [N_PHASES] = '{8, 5, 7, 16, 4, 0, 3000, 6, 2048, 1, 9, 3};
    int unsigned ph_h [N_PHASES] = '{6, 4, 3, 5, 3, 3, 1, 4095, 1, 2048, 9, 2};
    int unsigned ph_n [N_PHASES] = '{100, 200, 150, 130, 80, 100, 40, 60, 40, 40, 150, 100};
    bif_pkg::res_t none;
    none = '0;
    rst_n = 1'b0; push = 1'b0; pop = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = bif_pkg::CFG_RADIUS; cfg_data = '0;
    cycle_cnt = 0; n_errors = 0; n_results = 0; n_items = 0;
    hold_tag = 0; seen_tag = 0; hold_cnt = 0;
    send_idle = 22; recv_idle = 60;
    reg_radius = 1; reg_width = 640; reg_height = 480;
    restart_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both tables so that no unwritten entry is ever read
    for (int i = 0; i < bif_pkg::SP_ENTRIES; i++)
      send_request(mk(bif_pkg::CMD_LOAD_SP, 0, i, 16'hFFFF), 0, none);
    for (int i = 0; i < bif_pkg::RG_ENTRIES; i++)
      send_request(mk(bif_pkg::CMD_LOAD_RG, 0, i, 16'hFFFF), 0, none);
    settle();
    set_frame(1, 1, 1);

    // single-pixel frame: full weights pass the center through unchanged
    dir_rows.push_back('{mk(bif_pkg::CMD_PIXEL, 4095, 0, 0), 1, '{12'd4095, 1'b0, 1'b1}});
    dir_rows.push_back('{mk(bif_pkg::CMD_PIXEL, 0, 511, 16'hFFFF), 1, '{12'd0, 1'b0, 1'b1}});
    dir_rows.push_back('{mk(bif_pkg::CMD_FLUSH, 4095, 511, 16'hFFFF), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_RG, 0, 256, 0), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_PIXEL, 2048, 0, 0), 1, '{12'd0, 1'b1, 1'b1}});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_RG, 0, 256, 16'hFFFF), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_SP, 0, 31, 0), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_SP, 0, 511, 0), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_PIXEL, 1234, 0, 0), 1, '{12'd1234, 1'b0, 1'b1}});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_SP, 0, 30, 16'hFFFF), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_RG, 0, 0, 16'hFFFF), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_RG, 0, 511, 16'h0001), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_SP, 0, 1, 16'h8000), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_PIXEL, 100, 0, 0), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_FLUSH, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_SP, 0, 1, 16'h0000), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_PIXEL, 3000, 0, 0), 0, none});
    dir_rows.push_back('{mk(bif_pkg::CMD_LOAD_SP, 0, 1, 16'hFFFF), 0, none});
    foreach (dir_rows[i]) send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 4) begin send_idle = 22; recv_idle = 60; end
      else if (ph < 8) begin send_idle = 60; recv_idle = 22; end
      else begin send_idle = 0; recv_idle = 0; end
      set_frame(ph_r[ph], ph_w[ph], ph_h[ph]);
      // in the first phase, hold the result side while requests keep coming, so the block backs up
      if (ph == 0) hold_tag <= hold_tag + 1;
      for (int n = 0; n < ph_n[ph]; n++) send_request(rand_request(), 0, none);
      settle();
    end

    $display("covered %0d requests and %0d results over %0d frame settings",
             n_items, n_results, N_PHASES);
    $display("table loads, flush drains, zero weights and clamped registers included");
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: bilateral_image_filter.f
rtl/bif_pkg.sv
rtl/bif_front.sv
rtl/bif_outq.sv
rtl/bif_back.sv
rtl/bilateral_image_filter.sv
tb/tb.sv
